// File: rtl/kdn_pkg.sv
`default_nettype none
package kdn_pkg;

   localparam int ROWS = 4;
   localparam int COLS = 4;
   localparam int KEYS = ROWS * COLS;
   localparam int KEY_W = $clog2(KEYS);
   localparam int ROW_W = 2;
   localparam int COL_W = $clog2(COLS);
   localparam int NOTE_W = 7;
   localparam int NOTES_W = 4 * NOTE_W;
   localparam int CNT_W = 4;
   localparam int CH_W = 4;
   localparam int CODE_W = 4;
   localparam int STATUS_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = NOTES_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOTES_COL0 = 3'd0,
      CSR_NOTES_COL1 = 3'd1,
      CSR_NOTES_COL2 = 3'd2,
      CSR_NOTES_COL3 = 3'd3,
      CSR_DEBOUNCE   = 3'd4,
      CSR_CHANNEL    = 3'd5
   } csr_index_type;

   localparam logic [CODE_W-1:0]   CODE_NOTE_ON  = 4'h9;
   localparam logic [CODE_W-1:0]   CODE_NOTE_OFF = 4'h8;
   localparam logic [STATUS_W-1:0] STAT_NOTE_ON  = 8'h90;
   localparam logic [STATUS_W-1:0] STAT_NOTE_OFF = 8'h80;
   localparam logic [NOTE_W-1:0]   VEL_NOTE_ON   = 7'd127;
   localparam logic [NOTE_W-1:0]   VEL_NOTE_OFF  = 7'd0;

   localparam logic [3:0][NOTES_W-1:0] NOTES_RESET = {
      28'd181742033, 28'd166946378, 28'd152167107, 28'd137371452
   };
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 4'd5;
   localparam logic [CH_W-1:0]  CHANNEL_RESET  = 4'd0;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic key_event;
      logic out_free;
      logic last_key;
   } status_type;

   function automatic logic [NOTE_W-1:0] note_of(input logic [NOTES_W-1:0] word,
                                                 input logic [ROW_W-1:0] row);
      logic [NOTE_W-1:0] n;
      case (row)
         2'd0: n = word[6:0];
         2'd1: n = word[13:7];
         2'd2: n = word[20:14];
         2'd3: n = word[27:21];
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// File: rtl/kdn_channels.sv
`default_nettype none
interface kdn_req_if;
   logic valid;
   logic ready;
   logic [kdn_pkg::COLS-1:0] row0_sample_a;
   logic [kdn_pkg::COLS-1:0] row0_sample_b;
   logic [kdn_pkg::COLS-1:0] row1_sample_a;
   logic [kdn_pkg::COLS-1:0] row1_sample_b;
   logic [kdn_pkg::COLS-1:0] row2_sample_a;
   logic [kdn_pkg::COLS-1:0] row2_sample_b;
   logic [kdn_pkg::COLS-1:0] row3_sample_a;
   logic [kdn_pkg::COLS-1:0] row3_sample_b;
   logic host_connected;

   modport source (
      output valid, row0_sample_a, row0_sample_b, row1_sample_a, row1_sample_b,
             row2_sample_a, row2_sample_b, row3_sample_a, row3_sample_b, host_connected,
      input  ready
   );
   modport sink (
      input  valid, row0_sample_a, row0_sample_b, row1_sample_a, row1_sample_b,
             row2_sample_a, row2_sample_b, row3_sample_a, row3_sample_b, host_connected,
      output ready
   );
endinterface

interface kdn_rsp_if;
   logic valid;
   logic ready;
   logic [kdn_pkg::CODE_W-1:0]   code_index;
   logic [kdn_pkg::STATUS_W-1:0] status_byte;
   logic [kdn_pkg::NOTE_W-1:0]   note;
   logic [kdn_pkg::NOTE_W-1:0]   velocity;
   logic [kdn_pkg::ROW_W-1:0]    key_row;
   logic [kdn_pkg::COL_W-1:0]    key_col;
   logic last_event;

   modport source (
      output valid, code_index, status_byte, note, velocity, key_row, key_col, last_event,
      input  ready
   );
   modport sink (
      input  valid, code_index, status_byte, note, velocity, key_row, key_col, last_event,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/kdn_ctrl.sv
`default_nettype none
module kdn_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire kdn_pkg::status_type status,
   output kdn_pkg::cmd_type         cmd
);

   kdn_pkg::state_type state_ff;
   kdn_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         kdn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = kdn_pkg::ST_SCAN;
            end
         end
         kdn_pkg::ST_SCAN: begin
            // stall only when this key emits and the output beat is still held
            if (!status.key_event || status.out_free) begin
               cmd.step = 1'b1;
               if (status.last_key) begin
                  cmd.finish = 1'b1;
                  state_in   = kdn_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = kdn_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/kdn_datapath.sv
`default_nettype none
module kdn_datapath (
   input  wire                                                clock,
   input  wire                                                reset,
   input  wire kdn_pkg::cmd_type                              cmd,
   output kdn_pkg::status_type                                status,
   input  wire [kdn_pkg::ROWS-1:0][kdn_pkg::COLS-1:0]         scan_a,
   input  wire [kdn_pkg::ROWS-1:0][kdn_pkg::COLS-1:0]         scan_b,
   input  wire                                                scan_host,
   input  wire                                                csr_write_enable,
   input  wire [kdn_pkg::CSR_IDX_W-1:0]                       csr_index,
   input  wire [kdn_pkg::CSR_DATA_W-1:0]                      csr_write_data,
   output logic                                               rsp_valid,
   input  wire                                                rsp_ready,
   output logic [kdn_pkg::CODE_W-1:0]                         rsp_code_index,
   output logic [kdn_pkg::STATUS_W-1:0]                       rsp_status_byte,
   output logic [kdn_pkg::NOTE_W-1:0]                         rsp_note,
   output logic [kdn_pkg::NOTE_W-1:0]                         rsp_velocity,
   output logic [kdn_pkg::ROW_W-1:0]                          rsp_key_row,
   output logic [kdn_pkg::COL_W-1:0]                          rsp_key_col,
   output logic                                               rsp_last_event
);

   localparam int ROWS = kdn_pkg::ROWS;
   localparam int COLS = kdn_pkg::COLS;
   localparam int KEYS = kdn_pkg::KEYS;

   // configuration
   logic [3:0][kdn_pkg::NOTES_W-1:0] notes_ff, notes_in;
   logic [kdn_pkg::CNT_W-1:0]        debounce_ff, debounce_in;
   logic [kdn_pkg::CH_W-1:0]         channel_ff, channel_in;

   // debounce and scan state
   logic [ROWS-1:0][COLS-1:0]           settled_ff, settled_in;
   logic [ROWS-1:0][COLS-1:0]           previous_ff, previous_in;
   logic [ROWS-1:0][COLS-1:0]           candidate_ff, candidate_in;
   logic [ROWS-1:0][kdn_pkg::CNT_W-1:0] count_ff, count_in;
   logic                                host_ff, host_in;
   logic [kdn_pkg::KEY_W-1:0]           key_ff, key_in;
   logic [KEYS-1:0]                     held_valid_ff, held_valid_in;
   logic [kdn_pkg::NOTE_W-1:0]          held_note_ff [KEYS];

   // output beat
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kdn_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [kdn_pkg::STATUS_W-1:0] stat_ff, stat_in;
   logic [kdn_pkg::NOTE_W-1:0]   note_ff, note_in;
   logic [kdn_pkg::NOTE_W-1:0]   vel_ff, vel_in;
   logic [kdn_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [kdn_pkg::COL_W-1:0]    col_ff, col_in;
   logic                         last_ff, last_in;

   logic [KEYS-1:0]            on_ev, off_ev, key_ev, later_ev;
   logic [kdn_pkg::ROW_W-1:0]  key_row;
   logic [kdn_pkg::COL_W-1:0]  key_col;
   logic [kdn_pkg::NOTE_W-1:0] table_note;
   logic                       emit, emit_on;

   assign key_row    = key_ff[kdn_pkg::KEY_W-1:kdn_pkg::COL_W];
   assign key_col    = key_ff[kdn_pkg::COL_W-1:0];
   assign table_note = kdn_pkg::note_of(notes_ff[key_col], key_row);

   always_comb begin
      for (int i = 0; i < KEYS; i++) begin
         on_ev[i]  = previous_ff[i / COLS][i % COLS] && !settled_ff[i / COLS][i % COLS] &&
                     !held_valid_ff[i];
         off_ev[i] = !previous_ff[i / COLS][i % COLS] && settled_ff[i / COLS][i % COLS] &&
                     held_valid_ff[i];
         key_ev[i] = host_ff && (on_ev[i] || off_ev[i]);
      end
   end

   assign later_ev = (key_ev >> key_ff) >> 1;
   assign emit     = cmd.step && key_ev[key_ff];
   assign emit_on  = on_ev[key_ff];

   assign status.key_event = key_ev[key_ff];
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.last_key  = key_ff == kdn_pkg::KEY_W'(KEYS - 1);

   always_comb begin
      logic [kdn_pkg::CNT_W-1:0] cnt;

      notes_in      = notes_ff;
      debounce_in   = debounce_ff;
      channel_in    = channel_ff;
      settled_in    = settled_ff;
      previous_in   = previous_ff;
      candidate_in  = candidate_ff;
      count_in      = count_ff;
      host_in       = host_ff;
      key_in        = key_ff;
      held_valid_in = held_valid_ff;
      cnt           = '0;

      if (csr_write_enable) begin
         case (kdn_pkg::csr_index_type'(csr_index))
            kdn_pkg::CSR_NOTES_COL0: notes_in[0] = csr_write_data;
            kdn_pkg::CSR_NOTES_COL1: notes_in[1] = csr_write_data;
            kdn_pkg::CSR_NOTES_COL2: notes_in[2] = csr_write_data;
            kdn_pkg::CSR_NOTES_COL3: notes_in[3] = csr_write_data;
            kdn_pkg::CSR_DEBOUNCE:   debounce_in = csr_write_data[kdn_pkg::CNT_W-1:0];
            kdn_pkg::CSR_CHANNEL:    channel_in  = csr_write_data[kdn_pkg::CH_W-1:0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         host_in = scan_host;
         key_in  = '0;
         for (int r = 0; r < ROWS; r++) begin
            if (scan_a[r] != scan_b[r]) begin
               count_in[r] = '0;
            end else if (scan_a[r] == candidate_ff[r]) begin
               cnt = count_ff[r];
               if (cnt < debounce_ff) begin
                  cnt = cnt + 1'b1;
               end
               count_in[r] = cnt;
               if (cnt >= debounce_ff) begin
                  settled_in[r] = scan_a[r];
               end
            end else begin
               candidate_in[r] = scan_a[r];
               count_in[r]     = kdn_pkg::CNT_W'(1);
            end
         end
      end

      if (cmd.step) begin
         key_in = key_ff + 1'b1;
      end
      if (emit) begin
         held_valid_in[key_ff] = emit_on;
      end
      if (cmd.finish) begin
         previous_in = settled_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      code_in      = code_ff;
      stat_in      = stat_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         code_in      = emit_on ? kdn_pkg::CODE_NOTE_ON : kdn_pkg::CODE_NOTE_OFF;
         stat_in      = (emit_on ? kdn_pkg::STAT_NOTE_ON : kdn_pkg::STAT_NOTE_OFF) |
                        {{(kdn_pkg::STATUS_W - kdn_pkg::CH_W){1'b0}}, channel_ff};
         note_in      = emit_on ? table_note : held_note_ff[key_ff];
         vel_in       = emit_on ? kdn_pkg::VEL_NOTE_ON : kdn_pkg::VEL_NOTE_OFF;
         row_in       = key_row;
         col_in       = key_col;
         last_in      = ~|later_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         notes_ff      <= kdn_pkg::NOTES_RESET;
         debounce_ff   <= kdn_pkg::DEBOUNCE_RESET;
         channel_ff    <= kdn_pkg::CHANNEL_RESET;
         settled_ff    <= '1;
         previous_ff   <= '1;
         candidate_ff  <= '1;
         count_ff      <= '0;
         host_ff       <= 1'b0;
         key_ff        <= '0;
         held_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         notes_ff      <= notes_in;
         debounce_ff   <= debounce_in;
         channel_ff    <= channel_in;
         settled_ff    <= settled_in;
         previous_ff   <= previous_in;
         candidate_ff  <= candidate_in;
         count_ff      <= count_in;
         host_ff       <= host_in;
         key_ff        <= key_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && emit_on) begin
         held_note_ff[key_ff] <= table_note;
      end
      code_ff <= code_in;
      stat_ff <= stat_in;
      note_ff <= note_in;
      vel_ff  <= vel_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_index  = code_ff;
   assign rsp_status_byte = stat_ff;
   assign rsp_note        = note_ff;
   assign rsp_velocity    = vel_ff;
   assign rsp_key_row     = row_ff;
   assign rsp_key_col     = col_ff;
   assign rsp_last_event  = last_ff;

endmodule
`default_nettype wire

// File: rtl/keypad_debounce_note_events_top.sv
// channel  | dir | handshake       | beat
// req_ch   | in  | valid/ready     | one 4x4 scan: two column samples per row, host flag
// rsp_ch   | out | valid/ready     | one note event, last_event marks the scan's final one
// csr_*    | in  | write enable    | register index and 28-bit data, no read-back
//
// A scan first takes the beat and debounces all rows, then the sequencer walks
// the 16 keys in row-major order.
// Each event waits in a single output register; a held event stalls the walk.
// The next scan is taken as soon as the walk ends, even if the last event waits.
// Synchronous active-high reset restores the registers and releases all keys.
`default_nettype none
module keypad_debounce_note_events_top (
   input  wire                              clock,
   input  wire                              reset,
   kdn_req_if.sink                          req_ch,
   kdn_rsp_if.source                        rsp_ch,
   input  wire                              csr_write_enable,
   input  wire [kdn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [kdn_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   kdn_pkg::cmd_type    cmd;
   kdn_pkg::status_type status;
   logic [kdn_pkg::ROWS-1:0][kdn_pkg::COLS-1:0] scan_a, scan_b;

   assign scan_a = {req_ch.row3_sample_a, req_ch.row2_sample_a,
                    req_ch.row1_sample_a, req_ch.row0_sample_a};
   assign scan_b = {req_ch.row3_sample_b, req_ch.row2_sample_b,
                    req_ch.row1_sample_b, req_ch.row0_sample_b};

   kdn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kdn_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .scan_a           (scan_a),
      .scan_b           (scan_b),
      .scan_host        (req_ch.host_connected),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_code_index   (rsp_ch.code_index),
      .rsp_status_byte  (rsp_ch.status_byte),
      .rsp_note         (rsp_ch.note),
      .rsp_velocity     (rsp_ch.velocity),
      .rsp_key_row      (rsp_ch.key_row),
      .rsp_key_col      (rsp_ch.key_col),
      .rsp_last_event   (rsp_ch.last_event)
   );

endmodule
`default_nettype wire

// File: rtl/kdn_checker.sv
`default_nettype none
module kdn_checker (
   input  wire        clock,
   input  wire        reset,
   kdn_req_if.sink    req_ch,
   kdn_rsp_if.source  rsp_ch
);

   // output beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.note) &&
      $stable(rsp_ch.key_row) && $stable(rsp_ch.key_col) && $stable(rsp_ch.last_event))
      else $error("rsp beat changed while stalled");

   // one scan at a time
   a_one_scan: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("scan taken while previous scan in progress");

   a_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         (rsp_ch.code_index == kdn_pkg::CODE_NOTE_ON &&
          rsp_ch.velocity == kdn_pkg::VEL_NOTE_ON) ||
         (rsp_ch.code_index == kdn_pkg::CODE_NOTE_OFF &&
          rsp_ch.velocity == kdn_pkg::VEL_NOTE_OFF))
      else $error("velocity does not match event code");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.status_byte[7:4] == rsp_ch.code_index)
      else $error("status byte does not match event code");

endmodule

bind keypad_debounce_note_events_top kdn_checker u_kdn_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kdn_pkg::*;

   localparam int LONG_HOLD     = 1500;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_GAP       = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE7 = 3'd7;

   typedef struct packed {
      logic [ROWS-1:0][COLS-1:0] sa;
      logic [ROWS-1:0][COLS-1:0] sb;
      logic                      host;
   } scan_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [STATUS_W-1:0] status;
      logic [NOTE_W-1:0]   note;
      logic [NOTE_W-1:0]   vel;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic                last;
   } note_event_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   kdn_req_if scan_if ();
   kdn_rsp_if event_if ();

   keypad_debounce_note_events_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (scan_if),
      .rsp_ch           (event_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of registers and key state
   logic [NOTES_W-1:0] cfg_notes [4];
   logic [CNT_W-1:0]   cfg_debounce;
   logic [CH_W-1:0]    cfg_channel;
   logic [COLS-1:0]    kp_settled [ROWS];
   logic [COLS-1:0]    kp_prev    [ROWS];
   logic [COLS-1:0]    kp_cand    [ROWS];
   logic [CNT_W-1:0]   kp_count   [ROWS];
   logic [NOTE_W-1:0]  held_note  [ROWS][COLS];
   logic               held_on    [ROWS][COLS];

   scan_type       scan_backlog [$];
   note_event_type pending_events [$];
   scan_type       live_scan;

   int   send_gap;
   int   stall_left;
   int   hold_left;
   int   mismatches;
   logic send_fast;
   logic recv_fast;
   logic long_hold_req;
   logic hold_done;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic scan_type make_scan(input logic [15:0] a, input logic [15:0] b,
                                          input logic host);
      scan_type s;
      s.sa   = a;
      s.sb   = b;
      s.host = host;
      return s;
   endfunction

   task automatic predict_note_events(input scan_type s);
      note_event_type ev;
      note_event_type scan_events [$];
      logic [COLS-1:0] a, b;
      logic cur, prv;
      for (int r = 0; r < ROWS; r++) begin
         a = s.sa[r];
         b = s.sb[r];
         if (a != b) begin
            kp_count[r] = '0;
         end else if (a == kp_cand[r]) begin
            if (kp_count[r] < cfg_debounce) kp_count[r] = kp_count[r] + 1'b1;
            if (kp_count[r] >= cfg_debounce) kp_settled[r] = a;
         end else begin
            kp_cand[r]  = a;
            kp_count[r] = 4'd1;
         end
      end
      if (s.host) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               cur = kp_settled[r][c];
               prv = kp_prev[r][c];
               ev.row  = ROW_W'(r);
               ev.col  = COL_W'(c);
               ev.last = 1'b0;
               if (prv && !cur && !held_on[r][c]) begin
                  ev.code   = CODE_NOTE_ON;
                  ev.status = STAT_NOTE_ON | {4'b0, cfg_channel};
                  ev.note   = cfg_notes[c][NOTE_W*r +: NOTE_W];
                  ev.vel    = VEL_NOTE_ON;
                  held_note[r][c] = ev.note;
                  held_on[r][c]   = 1'b1;
                  scan_events.push_back(ev);
               end else if (!prv && cur && held_on[r][c]) begin
                  ev.code   = CODE_NOTE_OFF;
                  ev.status = STAT_NOTE_OFF | {4'b0, cfg_channel};
                  ev.note   = held_note[r][c];
                  ev.vel    = VEL_NOTE_OFF;
                  held_note[r][c] = '0;
                  held_on[r][c]   = 1'b0;
                  scan_events.push_back(ev);
               end
            end
         end
         if (scan_events.size() != 0) scan_events[scan_events.size()-1].last = 1'b1;
      end
      foreach (scan_events[i]) pending_events.push_back(scan_events[i]);
      for (int r = 0; r < ROWS; r++) kp_prev[r] = kp_settled[r];
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // scan driver
   always @(posedge clock) begin : scan_driver
      logic offering;
      if (reset) begin
         scan_if.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         offering = scan_if.valid;
         if (scan_if.valid && scan_if.ready) begin
            predict_note_events(live_scan);
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap != 0) begin
               send_gap      <= send_gap - 1;
               scan_if.valid <= 1'b0;
            end else if (scan_backlog.size() != 0) begin
               live_scan = scan_backlog.pop_front();
               scan_if.valid          <= 1'b1;
               scan_if.row0_sample_a  <= live_scan.sa[0];
               scan_if.row0_sample_b  <= live_scan.sb[0];
               scan_if.row1_sample_a  <= live_scan.sa[1];
               scan_if.row1_sample_b  <= live_scan.sb[1];
               scan_if.row2_sample_a  <= live_scan.sa[2];
               scan_if.row2_sample_b  <= live_scan.sb[2];
               scan_if.row3_sample_a  <= live_scan.sa[3];
               scan_if.row3_sample_b  <= live_scan.sb[3];
               scan_if.host_connected <= live_scan.host;
               send_gap <= send_fast ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
               scan_if.valid <= 1'b0;
            end
         end
      end
   end

   // event monitor
   always @(posedge clock) begin : event_monitor
      logic took;
      note_event_type want;
      int n;
      if (reset) begin
         event_if.ready <= 1'b0;
         stall_left     <= 0;
         hold_left      <= 0;
         hold_done      <= 1'b0;
      end else begin
         took = event_if.valid && event_if.ready;
         if (took) begin
            if (pending_events.size() == 0) begin
               $error("note event beat with nothing expected: note %0d row %0d col %0d",
                      event_if.note, event_if.key_row, event_if.key_col);
               mismatches++;
            end else begin
               want = pending_events.pop_front();
               check_field("code_index", want.code, event_if.code_index);
               check_field("status_byte", want.status, event_if.status_byte);
               check_field("note", want.note, event_if.note);
               check_field("velocity", want.vel, event_if.velocity);
               check_field("key_row", want.row, event_if.key_row);
               check_field("key_col", want.col, event_if.key_col);
               check_field("last_event", want.last, event_if.last_event);
            end
         end
         if (long_hold_req && !hold_done) begin
            hold_done      <= 1'b1;
            hold_left      <= LONG_HOLD;
            event_if.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            event_if.ready <= (hold_left == 1);
         end else if (took) begin
            n = recv_fast ? 0 : $urandom_range(0, MAX_GAP);
            stall_left     <= n;
            event_if.ready <= (n == 0);
         end else if (stall_left != 0) begin
            stall_left     <= stall_left - 1;
            event_if.ready <= (stall_left == 1);
         end else begin
            event_if.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_NOTES_COL0, CSR_NOTES_COL1, CSR_NOTES_COL2, CSR_NOTES_COL3:
            cfg_notes[idx[1:0]] = data;
         CSR_DEBOUNCE: cfg_debounce = data[CNT_W-1:0];
         CSR_CHANNEL:  cfg_channel  = data[CH_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (scan_backlog.size() != 0 || scan_if.valid || pending_events.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_notes();
      csr_write(CSR_NOTES_COL0, CSR_DATA_W'($urandom()));
      csr_write(CSR_NOTES_COL1, CSR_DATA_W'($urandom()));
      csr_write(CSR_NOTES_COL2, CSR_DATA_W'($urandom()));
      csr_write(CSR_NOTES_COL3, CSR_DATA_W'($urandom()));
   endtask

   // mostly stable patterns held long enough to settle, with bounce and host drops
   task automatic queue_random_scans(input int count);
      logic [ROWS-1:0][COLS-1:0] pat, a, b;
      logic host;
      int reps, made, rr;
      pat  = '1;
      made = 0;
      @(negedge clock);
      while (made < count) begin
         for (int r = 0; r < ROWS; r++) begin
            case ($urandom_range(0, 3))
               0: pat[r] = COLS'($urandom_range(0, 15));
               1: pat[r] = pat[r] ^ (4'd1 << $urandom_range(0, 3));
               default: ;
            endcase
         end
         host = ($urandom_range(0, 9) != 0);
         reps = cfg_debounce + 1 + $urandom_range(0, 2);
         for (int i = 0; i < reps && made < count; i++) begin
            a = pat;
            b = pat;
            if ($urandom_range(0, 7) == 0) begin
               rr    = $urandom_range(0, ROWS - 1);
               a[rr] = COLS'($urandom_range(0, 15));
               b[rr] = COLS'($urandom_range(0, 15));
            end
            scan_backlog.push_back(make_scan(a, b, host));
            made++;
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      scan_if.valid          = 1'b0;
      scan_if.row0_sample_a  = '1;
      scan_if.row0_sample_b  = '1;
      scan_if.row1_sample_a  = '1;
      scan_if.row1_sample_b  = '1;
      scan_if.row2_sample_a  = '1;
      scan_if.row2_sample_b  = '1;
      scan_if.row3_sample_a  = '1;
      scan_if.row3_sample_b  = '1;
      scan_if.host_connected = 1'b0;
      event_if.ready = 1'b0;
      send_fast      = 1'b0;
      recv_fast      = 1'b0;
      long_hold_req  = 1'b0;
      mismatches     = 0;
      for (int i = 0; i < 4; i++) cfg_notes[i] = NOTES_RESET[i];
      cfg_debounce = DEBOUNCE_RESET;
      cfg_channel  = CHANNEL_RESET;
      for (int r = 0; r < ROWS; r++) begin
         kp_settled[r] = '1;
         kp_prev[r]    = '1;
         kp_cand[r]    = '1;
         kp_count[r]   = '0;
         for (int c = 0; c < COLS; c++) begin
            held_note[r][c] = '0;
            held_on[r][c]   = 1'b0;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // directed: full press/release, bounce, host off, press while held
      csr_write(CSR_DEBOUNCE, 28'd1);
      @(negedge clock);
      repeat (2) scan_backlog.push_back(make_scan(16'h0000, 16'h0000, 1'b1));
      repeat (2) scan_backlog.push_back(make_scan(16'hFFFF, 16'hFFFF, 1'b1));
      scan_backlog.push_back(make_scan(16'h0000, 16'hFFFF, 1'b1));
      repeat (2) scan_backlog.push_back(make_scan(16'h0000, 16'h0000, 1'b0));
      repeat (2) scan_backlog.push_back(make_scan(16'hFFFF, 16'hFFFF, 1'b1));
      repeat (2) scan_backlog.push_back(make_scan(16'hFFFE, 16'hFFFE, 1'b1));
      repeat (2) scan_backlog.push_back(make_scan(16'hFFFF, 16'hFFFF, 1'b0));
      repeat (2) scan_backlog.push_back(make_scan(16'hFFFE, 16'hFFFE, 1'b1));
      repeat (2) scan_backlog.push_back(make_scan(16'hFFFF, 16'hFFFF, 1'b1));
      wait_idle();

      // note zero and 127, top channel, zero debounce
      csr_write(CSR_NOTES_COL0, 28'h0000000);
      csr_write(CSR_NOTES_COL1, 28'hFFFFFFF);
      csr_write(CSR_CHANNEL, 28'd15);
      csr_write(CSR_DEBOUNCE, 28'd0);
      @(negedge clock);
      repeat (2) scan_backlog.push_back(make_scan(16'h0000, 16'h0000, 1'b1));
      wait_idle();

      // held notes keep their numbers across a table change
      random_notes();
      csr_write(CSR_SPARE6, CSR_DATA_W'($urandom()));
      csr_write(CSR_SPARE7, CSR_DATA_W'($urandom()));
      csr_write(CSR_CHANNEL, 28'd5);
      csr_write(CSR_DEBOUNCE, 28'd2);
      @(negedge clock);
      repeat (3) scan_backlog.push_back(make_scan(16'hFFFF, 16'hFFFF, 1'b1));
      wait_idle();

      // random: fast sender against a long receiver hold
      random_notes();
      csr_write(CSR_DEBOUNCE, 28'd1);
      csr_write(CSR_CHANNEL, CSR_DATA_W'({$urandom_range(0, 16777215), 4'd0}));
      send_fast <= 1'b1;
      queue_random_scans(50);
      long_hold_req <= 1'b1;
      wait_idle();

      random_notes();
      csr_write(CSR_DEBOUNCE, 28'd15);
      csr_write(CSR_CHANNEL, CSR_DATA_W'($urandom_range(0, 15)));
      send_fast <= 1'b0;
      queue_random_scans(40);
      wait_idle();

      random_notes();
      csr_write(CSR_DEBOUNCE, CSR_DATA_W'({$urandom_range(0, 16777215), 4'd3}));
      csr_write(CSR_CHANNEL, CSR_DATA_W'($urandom_range(0, 15)));
      recv_fast <= 1'b1;
      queue_random_scans(45);
      wait_idle();

      random_notes();
      csr_write(CSR_DEBOUNCE, 28'd0);
      csr_write(CSR_CHANNEL, 28'd15);
      recv_fast <= 1'b0;
      queue_random_scans(45);
      wait_idle();

      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
